// ===== design/bubble_sort_engine_macros.svh =====
// ----------------------------------------------------------------------------
// bubble sort engine assertion macros
// shared property wrappers, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef BUBBLE_SORT_ENGINE_MACROS_SVH
`define BUBBLE_SORT_ENGINE_MACROS_SVH

// same-cycle implication
`define BSE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bubble_sort_engine: same-cycle check failed");

// next-cycle implication
`define BSE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bubble_sort_engine: next-cycle check failed");

`endif

// ===== design/bse_pkg.sv =====
// ----------------------------------------------------------------------------
// bse_pkg
// shared types and constants of the bubble sort engine
// ----------------------------------------------------------------------------
package bse_pkg;

    localparam int VALUE_BITS       = 32;
    localparam int INDEX_BITS       = 10;
    localparam int MAX_ELEMENTS_DEF = 1024;

    typedef enum logic
    {
        ACT_LOAD = 1'b0,
        ACT_READ = 1'b1
    } action_t;

    typedef logic signed [VALUE_BITS-1:0] value_t;

    typedef struct packed
    {
        action_t               action;
        value_t                value;
        logic                  last;
        logic [INDEX_BITS-1:0] index;
    } req_t;

    typedef struct packed
    {
        value_t sorted_value;
        logic   out_of_range;
    } rsp_t;

    typedef struct packed
    {
        logic load;
        logic read;
        logic out_capture;
        logic pass_first;
        logic pass_step;
        logic pass_end;
    } cmd_t;

    typedef struct packed
    {
        logic sort_short;
        logic step_last;
        logic pass_last;
        logic out_busy;
    } status_t;

endpackage

// ===== design/bubble_sort_engine.sv =====
// ----------------------------------------------------------------------------
// bubble_sort_engine
// loads a set of signed values, sorts it ascending and serves indexed reads
// ----------------------------------------------------------------------------
// A load request writes the next free element, if one is free; a load
// marked last closes the set and starts the sort, during which requests are
// stalled. With n loaded elements (n of two or more) the sort makes n-1
// passes; each pass streams the unsorted part once through the element
// memory (one read and one write per cycle), with pass setup in SRT_START
// and SRT_FIRST and wrap-up in SRT_END; a set of one element goes from
// SRT_START straight back to idle. A read request is taken, its element is
// registered and its response is loaded into the output register from
// RD_WAIT; the next request is taken while that response still waits in the
// output register. A read that finds the output register still occupied
// waits inside the engine and keeps requests stalled until the register
// frees up. The element memory needs no clearing after reset.
`include "bubble_sort_engine_macros.svh"

module bubble_sort_engine
#(
    parameter int MAX_ELEMENTS = bse_pkg::MAX_ELEMENTS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  bse_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output bse_pkg::rsp_t rsp
);
    import bse_pkg::*;

    cmd_t    cmd;
    status_t status;

    bse_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    bse_datapath
    #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .status    (status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // sort and read sequencing keeps the request side stalled
    `BSE_ASSERT_IMPL(a_busy_stalls, cmd.pass_first || cmd.pass_step || cmd.pass_end || cmd.out_capture, req_stall)
    // a captured read always shows up as a response
    `BSE_ASSERT_NEXT(a_capture_rsp, cmd.out_capture, rsp_valid)
    // at most one datapath operation per cycle
    `BSE_ASSERT_IMPL(a_one_cmd, 1'b1, $onehot0({cmd.load, cmd.read, cmd.out_capture, cmd.pass_first, cmd.pass_step, cmd.pass_end}))

endmodule

// ===== design/bse_ctrl.sv =====
// ----------------------------------------------------------------------------
// bse_ctrl
// control state machine: request intake, read sequencing and sort passes
// ----------------------------------------------------------------------------
module bse_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  bse_pkg::req_t   req,
    output logic            req_stall,
    input  bse_pkg::status_t status,
    output bse_pkg::cmd_t   cmd
);
    import bse_pkg::*;

    typedef enum logic [5:0]
    {
        ST_IDLE      = 6'b000001,
        ST_RD_WAIT   = 6'b000010,
        ST_SRT_START = 6'b000100,
        ST_SRT_FIRST = 6'b001000,
        ST_SRT_STEP  = 6'b010000,
        ST_SRT_END   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req.action == ACT_LOAD)
                    begin
                        cmd.load = 1'b1;
                        if (req.last)
                        begin
                            state_next = ST_SRT_START;
                        end
                    end
                    else
                    begin
                        cmd.read   = 1'b1;
                        state_next = ST_RD_WAIT;
                    end
                end
            end
            ST_RD_WAIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_capture = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_SRT_START:
            begin
                state_next = status.sort_short ? ST_IDLE : ST_SRT_FIRST;
            end
            ST_SRT_FIRST:
            begin
                cmd.pass_first = 1'b1;
                state_next     = ST_SRT_STEP;
            end
            ST_SRT_STEP:
            begin
                cmd.pass_step = 1'b1;
                if (status.step_last)
                begin
                    state_next = ST_SRT_END;
                end
            end
            ST_SRT_END:
            begin
                cmd.pass_end = 1'b1;
                state_next   = status.pass_last ? ST_IDLE : ST_SRT_START;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);

endmodule

// ===== design/bse_datapath.sv =====
// ----------------------------------------------------------------------------
// bse_datapath
// element memory, set counters, bubble pass registers and response register
// ----------------------------------------------------------------------------
module bse_datapath
#(
    parameter int MAX_ELEMENTS = bse_pkg::MAX_ELEMENTS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  bse_pkg::req_t    req,
    input  bse_pkg::cmd_t    cmd,
    output bse_pkg::status_t status,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output bse_pkg::rsp_t    rsp
);
    import bse_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int CMP_W  = (INDEX_BITS > CNT_W) ? INDEX_BITS : CNT_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ELEMENTS);
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_ELEMENTS);

    value_t mem [MAX_ELEMENTS];
    value_t rdata_reg;

    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    value_t            wr_data;

    logic [CNT_W-1:0] load_count_reg;
    logic [CNT_W-1:0] load_count_next;
    logic [CNT_W-1:0] sorted_count_reg;
    logic [CNT_W-1:0] sorted_count_next;
    logic             set_open_reg;
    logic             set_open_next;
    logic [CNT_W-1:0] pass_reg;
    logic [CNT_W-1:0] pass_next;
    logic [CNT_W-1:0] j_reg;
    logic [CNT_W-1:0] j_next;
    value_t           cur_reg;
    value_t           cur_next;
    logic             in_range_reg;
    logic             in_range_next;
    logic             rd_hold_reg;
    logic             rd_hold_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    logic [CNT_W-1:0] eff_count;
    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] j_prev;
    logic [CNT_W-1:0] j_inc;
    logic [CMP_W-1:0] idx_cmp;
    logic [CMP_W-1:0] sorted_cmp;
    logic             swap;

    assign eff_count  = set_open_reg ? load_count_reg : '0;
    assign limit      = load_count_reg - pass_reg;
    assign j_prev     = j_reg - CNT_W'(1);
    assign j_inc      = j_reg + CNT_W'(1);
    assign idx_cmp    = CMP_W'(req.index);
    assign sorted_cmp = CMP_W'(sorted_count_reg);
    assign swap       = (cur_reg > rdata_reg);

    always_comb
    begin
        rd_addr           = '0;
        wr_en             = 1'b0;
        wr_addr           = '0;
        wr_data           = cur_reg;
        load_count_next   = load_count_reg;
        sorted_count_next = sorted_count_reg;
        set_open_next     = set_open_reg;
        pass_next         = pass_reg;
        j_next            = j_reg;
        cur_next          = cur_reg;
        in_range_next     = in_range_reg;
        rd_hold_next      = rd_hold_reg;
        rsp_valid_next    = rsp_valid_reg;
        rsp_next          = rsp_reg;

        if (cmd.load)
        begin
            if (eff_count < MAX_CNT)
            begin
                wr_en           = 1'b1;
                wr_addr         = eff_count[ADDR_W-1:0];
                wr_data         = req.value;
                load_count_next = eff_count + CNT_W'(1);
            end
            else
            begin
                load_count_next = eff_count;
            end
            if (!set_open_reg)
            begin
                sorted_count_next = '0;
            end
            if (req.last)
            begin
                set_open_next     = 1'b0;
                sorted_count_next = load_count_next;
                pass_next         = CNT_W'(1);
            end
            else
            begin
                set_open_next = 1'b1;
            end
        end

        if (cmd.read)
        begin
            rd_addr       = idx_cmp[ADDR_W-1:0];
            in_range_next = (idx_cmp < sorted_cmp) && (idx_cmp < MAX_CMP);
            rd_hold_next  = 1'b1;
        end

        if (cmd.pass_first)
        begin
            rd_addr  = ADDR_W'(1);
            j_next   = CNT_W'(1);
            cur_next = rdata_reg;
        end

        if (cmd.pass_step)
        begin
            wr_en    = 1'b1;
            wr_addr  = j_prev[ADDR_W-1:0];
            wr_data  = swap ? rdata_reg : cur_reg;
            cur_next = swap ? cur_reg : rdata_reg;
            rd_addr  = j_inc[ADDR_W-1:0];
            j_next   = j_inc;
        end

        if (cmd.pass_end)
        begin
            wr_en     = 1'b1;
            wr_addr   = limit[ADDR_W-1:0];
            wr_data   = cur_reg;
            pass_next = pass_reg + CNT_W'(1);
        end

        if (cmd.out_capture)
        begin
            rd_hold_next          = 1'b0;
            rsp_valid_next        = 1'b1;
            rsp_next.sorted_value = in_range_reg ? rdata_reg : '0;
            rsp_next.out_of_range = !in_range_reg;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (!rd_hold_reg)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg   <= '0;
            sorted_count_reg <= '0;
            set_open_reg     <= 1'b0;
            pass_reg         <= '0;
            j_reg            <= '0;
            rd_hold_reg      <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            load_count_reg   <= load_count_next;
            sorted_count_reg <= sorted_count_next;
            set_open_reg     <= set_open_next;
            pass_reg         <= pass_next;
            j_reg            <= j_next;
            rd_hold_reg      <= rd_hold_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        in_range_reg <= in_range_next;
        rsp_reg      <= rsp_next;
    end

    assign status.sort_short = (load_count_reg < CNT_W'(2));
    assign status.step_last  = (j_reg == limit);
    assign status.pass_last  = (pass_reg == (load_count_reg - CNT_W'(1)));
    assign status.out_busy   = rsp_valid_reg && rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
